/* rtl/led_step_stream_queues_core_assert.svh */
`ifndef LED_STEP_STREAM_QUEUES_CORE_ASSERT_SVH
`define LED_STEP_STREAM_QUEUES_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LED_SSQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("led_ssq assertion failed");

// next-cycle implication, checked out of reset
`define LED_SSQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("led_ssq assertion failed");

`endif

/* rtl/led_ssq_pkg.sv */
package led_ssq_pkg;

    localparam int NUM_LEDS_DEF    = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PKT_BYTES       = 8;
    localparam int PCT_W           = 7;

    localparam logic [2:0] FN_STEP  = 3'd0;
    localparam logic [2:0] FN_DONE  = 3'd1;
    localparam logic [2:0] FN_STATE = 3'd2;
    localparam logic [2:0] FN_FETCH = 3'd3;
    localparam logic [2:0] FN_READY = 3'd4;
    localparam logic [2:0] FN_OFF   = 3'd5;

    localparam logic [2:0] K_STATUS  = 3'd0;
    localparam logic [2:0] K_PLAY    = 3'd1;
    localparam logic [2:0] K_REVERT  = 3'd2;
    localparam logic [2:0] K_REPORT  = 3'd3;
    localparam logic [2:0] K_VERDICT = 3'd4;

    localparam logic [2:0] SC_OK       = 3'd0;
    localparam logic [2:0] SC_NOT_INIT = 3'd1;
    localparam logic [2:0] SC_BAD_ID   = 3'd2;
    localparam logic [2:0] SC_BAD_LEN  = 3'd3;
    localparam logic [2:0] SC_ZERO_CNT = 3'd4;
    localparam logic [2:0] SC_FULL     = 3'd5;

    typedef struct packed {
        logic [PCT_W-1:0] red;
        logic [PCT_W-1:0] green;
        logic [PCT_W-1:0] blue;
        logic [15:0]      cnt;
        logic [15:0]      tim;
    } step_t;

    typedef struct packed {
        logic adv_wr;
        logic adv_rd;
        logic set_str;
        logic clr_str;
    } ptr_ctl_t;

    // floor(b * 100 / 255) via reciprocal: x / 255 = (x + (x >> 8) + 1) >> 8
    function automatic logic [PCT_W-1:0] to_pct(input logic [7:0] b);
        logic [14:0] x;
        logic [15:0] s;
        x = 15'(b) * 15'd100;
        s = 16'(x) + 16'(x[14:8]) + 16'd1;
        return s[14:8];
    endfunction

endpackage

/* rtl/led_ssq_ram.sv */
module led_ssq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/led_ssq_ptrs.sv */
module led_ssq_ptrs #(
    parameter int NUM_LEDS    = led_ssq_pkg::NUM_LEDS_DEF,
    parameter int QUEUE_DEPTH = led_ssq_pkg::QUEUE_DEPTH_DEF,
    localparam int RING = QUEUE_DEPTH + 1,
    localparam int PW   = $clog2(RING),
    localparam int LW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [LW-1:0]         idx,
    input  led_ssq_pkg::ptr_ctl_t ctl,
    output logic [PW-1:0]         wr_ptr,
    output logic [PW-1:0]         rd_ptr,
    output logic                  streaming,
    output logic [7:0]            free_cnt
);

    logic [PW-1:0]       wr_reg [NUM_LEDS];
    logic [PW-1:0]       rd_reg [NUM_LEDS];
    logic [NUM_LEDS-1:0] str_reg;
    logic [PW:0]         used_wide;
    logic [PW-1:0]       used;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH)) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr    = wr_reg[idx];
    assign rd_ptr    = rd_reg[idx];
    assign streaming = str_reg[idx];

    always_comb begin
        if (wr_ptr >= rd_ptr) begin
            used_wide = {1'b0, wr_ptr} - {1'b0, rd_ptr};
        end else begin
            used_wide = {1'b0, wr_ptr} + (PW+1)'(RING) - {1'b0, rd_ptr};
        end
        used     = used_wide[PW-1:0];
        free_cnt = 8'(QUEUE_DEPTH) - 8'(used);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                wr_reg[i] <= '0;
                rd_reg[i] <= '0;
            end
            str_reg <= '0;
        end else begin
            if (ctl.adv_wr) begin
                wr_reg[idx] <= advance(wr_ptr);
            end
            if (ctl.adv_rd) begin
                rd_reg[idx] <= advance(rd_ptr);
            end
            if (ctl.clr_str) begin
                str_reg[idx] <= 1'b0;
            end else if (ctl.set_str) begin
                str_reg[idx] <= 1'b1;
            end
        end
    end

endmodule

/* rtl/led_step_stream_queues_core.sv */
// Per-LED ring queues of LED effect steps. An item is accepted when the core is
// idle and the result register is empty or being emptied; its result is formed
// in the EXEC state after acceptance and lands in the result register, and no
// new item is taken before that. This comes from the registered read of the step
// store RAM, which is addressed at acceptance and consumed in the following cycle
// together with the pointer update and write-back. A fetch emits NUM_LEDS+1
// beats, one per cycle while the sink takes them, and no item is accepted until
// its last beat leaves. No clearing pass after reset.
module led_step_stream_queues_core #(
    parameter int NUM_LEDS    = led_ssq_pkg::NUM_LEDS_DEF,
    parameter int QUEUE_DEPTH = led_ssq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [7:0]  s_led_id,
    input  logic [7:0]  s_pkt_len,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [15:0] s_sub_count,
    input  logic [15:0] s_sub_time,
    input  logic        s_from_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_led_num,
    output logic [6:0]  m_red_pct,
    output logic [6:0]  m_green_pct,
    output logic [6:0]  m_blue_pct,
    output logic [15:0] m_step_count,
    output logic [15:0] m_step_time,
    output logic [7:0]  m_report,
    output logic [2:0]  m_status,
    output logic        m_last
);

    localparam int RING  = QUEUE_DEPTH + 1;
    localparam int PW    = $clog2(RING);
    localparam int LW    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int DEPTH = NUM_LEDS * RING;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $bits(led_ssq_pkg::step_t);
    localparam logic [AW-1:0] RING_A = AW'(RING);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        ready_flag_reg, ready_flag_next;
    logic [LW-1:0] fcnt_reg, fcnt_next;

    logic [2:0]  func_reg;
    logic [7:0]  id_reg;
    logic [7:0]  len_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [15:0] cnt_reg, tim_reg;
    logic        fs_reg;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  led_reg, led_next;
    led_ssq_pkg::step_t step_reg, step_next;
    logic [7:0]  report_reg, report_next;
    logic [2:0]  status_reg, status_next;
    logic        last_reg, last_next;

    logic        out_free;
    logic        accept;
    logic [7:0]  sel_id;
    logic        sel_bad;
    logic [LW-1:0] idx;

    led_ssq_pkg::ptr_ctl_t ctl;
    logic [PW-1:0] wr_ptr, rd_ptr;
    logic          streaming;
    logic [7:0]    free_cnt;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [SW-1:0] ram_rdata;
    led_ssq_pkg::step_t fresh, stored;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign sel_id  = (state_reg == S_IDLE) ? s_led_id : id_reg;
    assign sel_bad = (sel_id >= 8'(NUM_LEDS));

    always_comb begin
        if (state_reg == S_FETCH) begin
            idx = fcnt_reg;
        end else if (sel_bad) begin
            idx = '0;
        end else begin
            idx = sel_id[LW-1:0];
        end
    end

    led_ssq_ptrs #(
        .NUM_LEDS    (NUM_LEDS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ptrs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .idx       (idx),
        .ctl       (ctl),
        .wr_ptr    (wr_ptr),
        .rd_ptr    (rd_ptr),
        .streaming (streaming),
        .free_cnt  (free_cnt)
    );

    assign ram_raddr = AW'(idx) * RING_A + AW'(rd_ptr);
    assign ram_waddr = AW'(idx) * RING_A + AW'(wr_ptr);

    assign fresh.red   = led_ssq_pkg::to_pct(red_reg);
    assign fresh.green = led_ssq_pkg::to_pct(green_reg);
    assign fresh.blue  = led_ssq_pkg::to_pct(blue_reg);
    assign fresh.cnt   = cnt_reg;
    assign fresh.tim   = tim_reg;
    assign stored      = led_ssq_pkg::step_t'(ram_rdata);

    led_ssq_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (SW'(fresh)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        logic wrote;
        logic full;
        logic [2:0] st;
        wrote           = 1'b0;
        full            = (free_cnt == 8'd0);
        st              = led_ssq_pkg::SC_OK;
        state_next      = state_reg;
        ready_flag_next = ready_flag_reg;
        fcnt_next       = fcnt_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        kind_next       = kind_reg;
        led_next        = led_reg;
        step_next       = step_reg;
        report_next     = report_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        ctl             = '0;
        ram_we          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                kind_next      = led_ssq_pkg::K_STATUS;
                led_next       = id_reg;
                step_next      = '0;
                report_next    = 8'd0;
                status_next    = led_ssq_pkg::SC_OK;
                last_next      = 1'b1;
                unique case (func_reg)
                    led_ssq_pkg::FN_STEP: begin
                        if (!ready_flag_reg) begin
                            status_next = led_ssq_pkg::SC_NOT_INIT;
                        end else if (sel_bad) begin
                            status_next = led_ssq_pkg::SC_BAD_ID;
                        end else if (!full && len_reg != 8'(led_ssq_pkg::PKT_BYTES)) begin
                            status_next = led_ssq_pkg::SC_BAD_LEN;
                        end else if (!full && cnt_reg == 16'd0) begin
                            status_next = led_ssq_pkg::SC_ZERO_CNT;
                        end else begin
                            if (full) begin
                                st = led_ssq_pkg::SC_FULL;
                            end else begin
                                wrote      = 1'b1;
                                ram_we     = 1'b1;
                                ctl.adv_wr = 1'b1;
                            end
                            status_next = st;
                            if (!streaming) begin
                                if (wr_ptr != rd_ptr || wrote) begin
                                    ctl.set_str = 1'b1;
                                    ctl.adv_rd  = 1'b1;
                                    kind_next   = led_ssq_pkg::K_PLAY;
                                    step_next   = (wr_ptr == rd_ptr) ? fresh : stored;
                                end else begin
                                    kind_next = led_ssq_pkg::K_REVERT;
                                end
                            end
                        end
                    end
                    led_ssq_pkg::FN_DONE: begin
                        if (sel_bad) begin
                            status_next = led_ssq_pkg::SC_BAD_ID;
                        end else if (fs_reg) begin
                            if (wr_ptr != rd_ptr) begin
                                ctl.adv_rd = 1'b1;
                                kind_next  = led_ssq_pkg::K_PLAY;
                                step_next  = stored;
                            end else begin
                                ctl.clr_str = 1'b1;
                                kind_next   = led_ssq_pkg::K_REVERT;
                            end
                        end
                    end
                    led_ssq_pkg::FN_STATE: begin
                        kind_next = led_ssq_pkg::K_VERDICT;
                        if (sel_bad) begin
                            status_next = led_ssq_pkg::SC_BAD_ID;
                        end else begin
                            report_next = {7'd0, !fs_reg && streaming};
                        end
                    end
                    led_ssq_pkg::FN_FETCH: begin
                        kind_next   = led_ssq_pkg::K_REPORT;
                        led_next    = 8'd0;
                        report_next = {7'd0, ready_flag_reg};
                        last_next   = 1'b0;
                        fcnt_next   = '0;
                        state_next  = S_FETCH;
                    end
                    led_ssq_pkg::FN_READY: begin
                        ready_flag_next = 1'b1;
                    end
                    led_ssq_pkg::FN_OFF: begin
                        ready_flag_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            S_FETCH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    kind_next      = led_ssq_pkg::K_REPORT;
                    led_next       = 8'(fcnt_reg);
                    step_next      = '0;
                    report_next    = free_cnt;
                    status_next    = led_ssq_pkg::SC_OK;
                    last_next      = (fcnt_reg == LW'(NUM_LEDS - 1));
                    fcnt_next      = fcnt_reg + 1'b1;
                    if (fcnt_reg == LW'(NUM_LEDS - 1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ready_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fcnt_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            ready_flag_reg <= ready_flag_next;
            out_valid_reg  <= out_valid_next;
            fcnt_reg       <= fcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        led_reg    <= led_next;
        step_reg   <= step_next;
        report_reg <= report_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        if (accept) begin
            func_reg  <= s_func;
            id_reg    <= s_led_id;
            len_reg   <= s_pkt_len;
            red_reg   <= s_red;
            green_reg <= s_green;
            blue_reg  <= s_blue;
            cnt_reg   <= s_sub_count;
            tim_reg   <= s_sub_time;
            fs_reg    <= s_from_stream;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = kind_reg;
    assign m_led_num    = led_reg;
    assign m_red_pct    = step_reg.red;
    assign m_green_pct  = step_reg.green;
    assign m_blue_pct   = step_reg.blue;
    assign m_step_count = step_reg.cnt;
    assign m_step_time  = step_reg.tim;
    assign m_report     = report_reg;
    assign m_status     = status_reg;
    assign m_last       = last_reg;

endmodule

/* rtl/led_ssq_chk.sv */
`include "led_step_stream_queues_core_assert.svh"

module led_ssq_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_kind,
    input logic [6:0]  m_red_pct,
    input logic [6:0]  m_green_pct,
    input logic [6:0]  m_blue_pct,
    input logic [15:0] m_step_count,
    input logic [15:0] m_step_time,
    input logic [2:0]  m_status,
    input logic        m_last
);

    logic out_wait;
    logic pct_ok;
    logic not_play;
    logic step_clear;
    logic mid_fetch;
    logic fetch_beat;

    assign out_wait   = m_valid && !m_ready;
    assign pct_ok     = m_red_pct <= 7'd100 && m_green_pct <= 7'd100 && m_blue_pct <= 7'd100;
    assign not_play   = m_valid && m_kind != led_ssq_pkg::K_PLAY;
    assign step_clear = m_red_pct == 7'd0 && m_green_pct == 7'd0 && m_blue_pct == 7'd0
                        && m_step_count == 16'd0 && m_step_time == 16'd0;
    assign mid_fetch  = m_valid && !m_last;
    assign fetch_beat = !s_ready && m_kind == led_ssq_pkg::K_REPORT
                        && m_status == led_ssq_pkg::SC_OK;

    `LED_SSQ_ASSERT_NEXT(a_out_hold, out_wait, m_valid && $stable(m_kind) && $stable(m_last))
    `LED_SSQ_ASSERT_NOW(a_pct_range, m_valid, pct_ok)
    `LED_SSQ_ASSERT_NOW(a_step_zero, not_play, step_clear)
    `LED_SSQ_ASSERT_NOW(a_fetch_busy, mid_fetch, fetch_beat)

endmodule

bind led_step_stream_queues_core led_ssq_chk u_chk (.*);

/* bench/led_step_stream_queues_core_test.sv */
module led_step_stream_queues_core_test;

    localparam int LEDS         = led_ssq_pkg::NUM_LEDS_DEF;
    localparam int DEPTH        = led_ssq_pkg::QUEUE_DEPTH_DEF;
    localparam int RING         = DEPTH + 1;
    localparam int RANDOM_ITEMS = 185;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  led_id;
        logic [7:0]  pkt_len;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] sub_count;
        logic [15:0] sub_time;
        logic        from_stream;
    } led_cmd_t;

    localparam int CMD_W = $bits(led_cmd_t);

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  led_num;
        logic [6:0]  red_pct;
        logic [6:0]  green_pct;
        logic [6:0]  blue_pct;
        logic [15:0] play_count;
        logic [15:0] step_time;
        logic [7:0]  report;
        logic [2:0]  status;
        logic        last;
    } led_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_func;
    logic [7:0]  s_led_id;
    logic [7:0]  s_pkt_len;
    logic [7:0]  s_red;
    logic [7:0]  s_green;
    logic [7:0]  s_blue;
    logic [15:0] s_sub_count;
    logic [15:0] s_sub_time;
    logic        s_from_stream;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_kind;
    logic [7:0]  m_led_num;
    logic [6:0]  m_red_pct;
    logic [6:0]  m_green_pct;
    logic [6:0]  m_blue_pct;
    logic [15:0] m_step_count;
    logic [15:0] m_step_time;
    logic [7:0]  m_report;
    logic [2:0]  m_status;
    logic        m_last;

    led_step_stream_queues_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the LED queues
    led_ssq_pkg::step_t ring_store [LEDS][RING];
    int unsigned wr_pos [LEDS];
    int unsigned rd_pos [LEDS];
    bit          playing [LEDS];
    bit          leds_ready;

    led_result_t pending_results [$];
    int          result_errors;
    int          items_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [6:0] byte_to_percent(logic [7:0] b);
        return 7'((32'(b) * 100) / 255);
    endfunction

    function automatic int unsigned slots_left(int n);
        return DEPTH - ((RING + wr_pos[n] - rd_pos[n]) % RING);
    endfunction

    function automatic led_result_t make_result(logic [2:0] kind, logic [7:0] led,
                                                led_ssq_pkg::step_t st,
                                                logic [7:0] report, logic [2:0] status,
                                                logic last);
        led_result_t r;
        r.kind       = kind;
        r.led_num    = led;
        r.red_pct    = st.red;
        r.green_pct  = st.green;
        r.blue_pct   = st.blue;
        r.play_count = st.cnt;
        r.step_time  = st.tim;
        r.report     = report;
        r.status     = status;
        r.last       = last;
        return r;
    endfunction

    task automatic reset_queues();
        for (int i = 0; i < LEDS; i++) begin
            wr_pos[i]  = 0;
            rd_pos[i]  = 0;
            playing[i] = 1'b0;
            for (int j = 0; j < RING; j++) ring_store[i][j] = '0;
        end
        leds_ready = 1'b0;
    endtask

    // play the next queued step, or stop streaming and revert
    task automatic serve_next_step(int n, logic [2:0] status);
        if (wr_pos[n] != rd_pos[n]) begin
            pending_results.push_back(make_result(led_ssq_pkg::K_PLAY, 8'(n),
                                                  ring_store[n][rd_pos[n]],
                                                  8'd0, status, 1'b1));
            rd_pos[n] = (rd_pos[n] + 1) % RING;
        end else begin
            playing[n] = 1'b0;
            pending_results.push_back(make_result(led_ssq_pkg::K_REVERT, 8'(n), '0, 8'd0,
                                                  status, 1'b1));
        end
    endtask

    task automatic apply_led_cmd(led_cmd_t c);
        int         n;
        bit         bad_id;
        logic [2:0] status;
        led_ssq_pkg::step_t st;
        n      = int'(c.led_id);
        bad_id = (c.led_id >= 8'(LEDS));
        case (c.func)
            led_ssq_pkg::FN_STEP: begin
                if (!leds_ready) begin
                    status = led_ssq_pkg::SC_NOT_INIT;
                end else if (bad_id) begin
                    status = led_ssq_pkg::SC_BAD_ID;
                end else if (slots_left(n) == 0) begin
                    status = led_ssq_pkg::SC_FULL;
                end else if (c.pkt_len != 8'(led_ssq_pkg::PKT_BYTES)) begin
                    status = led_ssq_pkg::SC_BAD_LEN;
                end else if (c.sub_count == 16'd0) begin
                    status = led_ssq_pkg::SC_ZERO_CNT;
                end else begin
                    status    = led_ssq_pkg::SC_OK;
                    st.red    = byte_to_percent(c.red);
                    st.green  = byte_to_percent(c.green);
                    st.blue   = byte_to_percent(c.blue);
                    st.cnt    = c.sub_count;
                    st.tim    = c.sub_time;
                    ring_store[n][wr_pos[n]] = st;
                    wr_pos[n] = (wr_pos[n] + 1) % RING;
                end
                if ((status == led_ssq_pkg::SC_OK || status == led_ssq_pkg::SC_FULL)
                    && !playing[n]) begin
                    playing[n] = 1'b1;
                    serve_next_step(n, status);
                end else begin
                    pending_results.push_back(make_result(led_ssq_pkg::K_STATUS, c.led_id,
                                                          '0, 8'd0, status, 1'b1));
                end
            end
            led_ssq_pkg::FN_DONE: begin
                if (bad_id)
                    pending_results.push_back(make_result(led_ssq_pkg::K_STATUS, c.led_id,
                                                          '0, 8'd0, led_ssq_pkg::SC_BAD_ID,
                                                          1'b1));
                else if (c.from_stream)
                    serve_next_step(n, led_ssq_pkg::SC_OK);
                else
                    pending_results.push_back(make_result(led_ssq_pkg::K_STATUS, c.led_id,
                                                          '0, 8'd0, led_ssq_pkg::SC_OK,
                                                          1'b1));
            end
            led_ssq_pkg::FN_STATE: begin
                if (bad_id)
                    pending_results.push_back(make_result(led_ssq_pkg::K_VERDICT, c.led_id,
                                                          '0, 8'd0, led_ssq_pkg::SC_BAD_ID,
                                                          1'b1));
                else
                    pending_results.push_back(make_result(led_ssq_pkg::K_VERDICT, c.led_id,
                                                          '0,
                                                          8'(!c.from_stream && playing[n]),
                                                          led_ssq_pkg::SC_OK, 1'b1));
            end
            led_ssq_pkg::FN_FETCH: begin
                pending_results.push_back(make_result(led_ssq_pkg::K_REPORT, 8'd0, '0,
                                                      8'(leds_ready), led_ssq_pkg::SC_OK,
                                                      1'b0));
                for (int i = 0; i < LEDS; i++)
                    pending_results.push_back(make_result(led_ssq_pkg::K_REPORT, 8'(i), '0,
                                                          8'(slots_left(i)),
                                                          led_ssq_pkg::SC_OK,
                                                          i == LEDS - 1));
            end
            default: begin
                if (c.func == led_ssq_pkg::FN_READY) leds_ready = 1'b1;
                if (c.func == led_ssq_pkg::FN_OFF) leds_ready = 1'b0;
                pending_results.push_back(make_result(led_ssq_pkg::K_STATUS, c.led_id, '0,
                                                      8'd0, led_ssq_pkg::SC_OK, 1'b1));
            end
        endcase
    endtask

    task automatic send_item(led_cmd_t c);
        int gap;
        gap = pick_gap(send_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= c.func;
        s_led_id      <= c.led_id;
        s_pkt_len     <= c.pkt_len;
        s_red         <= c.red;
        s_green       <= c.green;
        s_blue        <= c.blue;
        s_sub_count   <= c.sub_count;
        s_sub_time    <= c.sub_time;
        s_from_stream <= c.from_stream;
        do @(posedge aclk); while (!s_ready);
        apply_led_cmd(c);
        items_sent++;
    endtask

    function automatic led_cmd_t event_cmd(logic [2:0] func, logic [7:0] id, logic fs);
        led_cmd_t c;
        c             = '0;
        c.func        = func;
        c.led_id      = id;
        c.from_stream = fs;
        return c;
    endfunction

    function automatic led_cmd_t step_cmd(logic [7:0] id, logic [7:0] len, logic [7:0] r,
                                          logic [7:0] g, logic [7:0] b, logic [15:0] cnt,
                                          logic [15:0] tim);
        led_cmd_t c;
        c           = event_cmd(led_ssq_pkg::FN_STEP, id, 1'b0);
        c.pkt_len   = len;
        c.red       = r;
        c.green     = g;
        c.blue      = b;
        c.sub_count = cnt;
        c.sub_time  = tim;
        return c;
    endfunction

    function automatic led_cmd_t random_step(logic [7:0] id, bit clean);
        led_cmd_t c;
        c = step_cmd(id, 8'(led_ssq_pkg::PKT_BYTES), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     16'($urandom_range(65535, 1)), 16'($urandom_range(65535)));
        c.from_stream = 1'($urandom_range(1));
        if (!clean && $urandom_range(11) == 0) c.pkt_len = 8'($urandom_range(255));
        if (!clean && $urandom_range(11) == 0) c.sub_count = 16'd0;
        return c;
    endfunction

    task automatic check_result();
        led_result_t got;
        led_result_t want;
        got = '{m_kind, m_led_num, m_red_pct, m_green_pct, m_blue_pct, m_step_count,
                m_step_time, m_report, m_status, m_last};
        if (pending_results.size() == 0) begin
            result_errors++;
            if (result_errors <= REPORT_LIMIT)
                $display("unexpected beat: kind=%0d led=%0d report=%0d status=%0d",
                         got.kind, got.led_num, got.report, got.status);
            return;
        end
        want = pending_results.pop_front();
        if (got !== want) begin
            result_errors++;
            if (result_errors <= REPORT_LIMIT) begin
                $display("expected: kind=%0d led=%0d pct=%0d/%0d/%0d cnt=%0d tim=%0d %s",
                         want.kind, want.led_num, want.red_pct, want.green_pct,
                         want.blue_pct, want.play_count, want.step_time,
                         $sformatf("rep=%0d st=%0d last=%0d", want.report, want.status,
                                   want.last));
                $display("actual:   kind=%0d led=%0d pct=%0d/%0d/%0d cnt=%0d tim=%0d %s",
                         got.kind, got.led_num, got.red_pct, got.green_pct,
                         got.blue_pct, got.play_count, got.step_time,
                         $sformatf("rep=%0d st=%0d last=%0d", got.report, got.status,
                                   got.last));
            end
        end
    endtask

    initial begin
        int stall_left;
        int gap;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_result();
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                gap = pick_gap(recv_idle_pct);
                if (gap > 0) begin
                    stall_left = gap - 1;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    task automatic test_before_init();
        send_item(step_cmd(8'd0, 8'(led_ssq_pkg::PKT_BYTES), 8'd255, 8'd255, 8'd255, 16'd1,
                           16'd1));
        send_item(event_cmd(led_ssq_pkg::FN_FETCH, 8'd0, 1'b0));
        send_item(event_cmd(led_ssq_pkg::FN_DONE, 8'd0, 1'b1));
        send_item(event_cmd(led_ssq_pkg::FN_STATE, 8'd1, 1'b0));
        send_item(event_cmd(FN_SPARE6, 8'd2, 1'b1));
        send_item(event_cmd(FN_SPARE7, 8'd3, 1'b0));
        send_item(event_cmd(led_ssq_pkg::FN_OFF, 8'd0, 1'b0));
    endtask

    task automatic test_packet_checks();
        logic [7:0] plen;
        plen = 8'(led_ssq_pkg::PKT_BYTES);
        send_item(event_cmd(led_ssq_pkg::FN_READY, 8'd0, 1'b0));
        send_item(step_cmd(8'd4, plen, 8'd10, 8'd20, 8'd30, 16'd5, 16'd5));
        send_item(step_cmd(8'd255, plen, 8'd10, 8'd20, 8'd30, 16'd5, 16'd5));
        send_item(step_cmd(8'd0, 8'd0, 8'd10, 8'd20, 8'd30, 16'd5, 16'd5));
        send_item(step_cmd(8'd0, 8'd255, 8'd10, 8'd20, 8'd30, 16'd5, 16'd5));
        send_item(step_cmd(8'd0, plen, 8'd10, 8'd20, 8'd30, 16'd0, 16'd5));
        send_item(step_cmd(8'd0, plen, 8'd255, 8'd0, 8'd128, 16'hffff, 16'hffff));
        send_item(step_cmd(8'd0, plen, 8'd1, 8'd254, 8'd3, 16'd1, 16'd0));
        send_item(event_cmd(led_ssq_pkg::FN_STATE, 8'd0, 1'b0));
        send_item(event_cmd(led_ssq_pkg::FN_STATE, 8'd0, 1'b1));
        send_item(event_cmd(led_ssq_pkg::FN_STATE, 8'd200, 1'b0));
        send_item(event_cmd(led_ssq_pkg::FN_DONE, 8'd0, 1'b0));
        send_item(event_cmd(led_ssq_pkg::FN_DONE, 8'd7, 1'b1));
        send_item(event_cmd(led_ssq_pkg::FN_DONE, 8'd0, 1'b1));
        send_item(event_cmd(led_ssq_pkg::FN_DONE, 8'd0, 1'b1));
        send_item(event_cmd(led_ssq_pkg::FN_FETCH, 8'd0, 1'b0));
    endtask

    task automatic test_queue_full();
        if (!leds_ready) send_item(event_cmd(led_ssq_pkg::FN_READY, 8'd0, 1'b0));
        repeat (DEPTH + 3) send_item(random_step(8'(LEDS - 1), 1'b1));
        send_item(event_cmd(led_ssq_pkg::FN_FETCH, 8'd0, 1'b0));
        send_item(event_cmd(led_ssq_pkg::FN_OFF, 8'd0, 1'b0));
        send_item(random_step(8'(LEDS - 1), 1'b1));
        send_item(event_cmd(led_ssq_pkg::FN_READY, 8'd0, 1'b0));
        repeat (DEPTH + 2) send_item(event_cmd(led_ssq_pkg::FN_DONE, 8'(LEDS - 1), 1'b1));
    endtask

    task automatic test_backpressure();
        int saved;
        saved         = send_idle_pct;
        send_idle_pct = 0;
        hold_req      = 1'b1;
        for (int i = 0; i < 20; i++) begin
            if (i % 4 == 0)
                send_item(event_cmd(led_ssq_pkg::FN_FETCH, 8'd0, 1'b0));
            else
                send_item(random_step(8'($urandom_range(LEDS - 1)), 1'b1));
        end
        send_idle_pct = saved;
    endtask

    task automatic test_random_traffic();
        int       target;
        int       sel;
        int       burst;
        logic [7:0] led;
        led_cmd_t c;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            send_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
            recv_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
            sel = $urandom_range(99);
            if (!leds_ready && $urandom_range(3) != 0)
                send_item(event_cmd(led_ssq_pkg::FN_READY, 8'($urandom_range(255)), 1'b0));
            if (sel < 55) begin
                led   = 8'($urandom_range(LEDS - 1));
                burst = $urandom_range(DEPTH + 3, 1);
                repeat (burst) send_item(random_step(led, 1'b0));
                repeat ($urandom_range(burst + 1)) begin
                    send_item(event_cmd(led_ssq_pkg::FN_DONE, led, $urandom_range(7) != 0));
                end
            end else if (sel < 85) begin
                c = random_step(8'($urandom_range(LEDS - 1)), 1'b0);
                c.func = 3'($urandom_range(5));
                if ($urandom_range(5) == 0) c.led_id = 8'($urandom_range(255));
                send_item(c);
            end else begin
                c = led_cmd_t'(CMD_W'({$urandom, $urandom, $urandom}));
                send_item(c);
            end
        end
    endtask

    initial begin
        reset_queues();
        result_errors = 0;
        items_sent    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b0;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_func        <= '0;
        s_led_id      <= '0;
        s_pkt_len     <= '0;
        s_red         <= '0;
        s_green       <= '0;
        s_blue        <= '0;
        s_sub_count   <= '0;
        s_sub_time    <= '0;
        s_from_stream <= 1'b0;
        m_ready       <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 30;
        recv_idle_pct = 30;
        test_before_init();
        test_packet_checks();
        test_queue_full();
        test_backpressure();
        test_random_traffic();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (result_errors == 0)
            $display("led_step_stream_queues_core_test passed");
        else
            $display("led_step_stream_queues_core_test failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("led_step_stream_queues_core_test failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/led_ssq_pkg.sv
rtl/led_ssq_ram.sv
rtl/led_ssq_ptrs.sv
rtl/led_step_stream_queues_core.sv
rtl/led_ssq_chk.sv
bench/led_step_stream_queues_core_test.sv
